FILE: rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ============================================================================
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int PRI_W = 8;
    localparam int TAG_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } spq_entry_t;

    // Operation broadcast to every cell in the chain
    typedef struct packed {
        logic       ins;
        logic       srv;
        spq_entry_t ent;
    } spq_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_in_if.sv
// ============================================================================
// spq_in_if
// Request channel: valid/ready handshake carrying one queue operation.
// ============================================================================
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PRI_W-1:0] priority_req;
    logic [TAG_W-1:0] tag;

    modport source (output valid, output mode, output priority_req, output tag,
                    input ready);
    modport sink   (input valid, input mode, input priority_req, input tag,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/spq_out_if.sv
// ============================================================================
// spq_out_if
// Response channel: valid/ready handshake carrying one queue result.
// ============================================================================
`default_nettype none

interface spq_out_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    served_priority;
    logic [TAG_W-1:0]    served_tag;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output served_priority,
                    output served_tag, output occupancy, input ready);
    modport sink   (input valid, input status, input served_priority,
                    input served_tag, input occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// below it, shifts left on serve.
// ============================================================================
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic       clk,
    input  wire spq_ctrl_t  ctrl,
    input  wire logic       live,
    input  wire logic       prev_gt,
    input  wire spq_entry_t left_entry,
    input  wire spq_entry_t right_entry,
    output logic            gt,
    output spq_entry_t      entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Empty slots count as greater so the new item lands at the first one
    assign gt = !live || (entry_reg.pri > ctrl.ent.pri);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && gt)
        begin
            // boundary cell takes the new item, cells past it shift right
            entry_next = prev_gt ? left_entry : ctrl.ent;
        end
        else if (ctrl.srv)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_unit.sv
// ============================================================================
// sorted_priority_queue_unit
// Bounded min-first priority queue built as a chain of sorting cells.
// ============================================================================
// Usage:
//   req carries one operation per item: mode insert (priority_req, tag) or
//   mode serve. rsp returns exactly one result per request: status, the
//   served entry's priority and tag (zero unless a serve succeeds), and the
//   occupancy after the operation. Equal priorities leave first-in first-out.
//   The result sits in the rsp register on the cycle after the request is
//   taken. Throughput is one item per cycle while rsp does not stall; every
//   cell compares its entry with the new priority and moves in the same cycle.
//   A serve on an empty queue returns the empty status, an insert on a full
//   queue returns the full status; neither changes the contents.
//   When rsp stalls, the held result stays in place and req ready drops
//   until it is taken. Reset empties the queue and clears rsp valid; the
//   block takes requests on the first cycle after reset.
// ============================================================================
`default_nettype none

module sorted_priority_queue_unit import spq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [PRI_W-1:0] pri_reg;
    logic [PRI_W-1:0] pri_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic [OCC_W-1:0] occ_reg;

    logic      accept;
    logic      full;
    logic      empty;
    spq_ctrl_t ctrl;

    logic [DEPTH-1:0] cell_gt;
    spq_entry_t       cell_entry [DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.ins     = accept && (req.mode == MODE_INSERT) && !full;
    assign ctrl.srv     = accept && (req.mode == MODE_SERVE) && !empty;
    assign ctrl.ent.pri = req.priority_req;
    assign ctrl.ent.tag = req.tag;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       live;
        logic       prev_gt;
        spq_entry_t left_entry;
        spq_entry_t right_entry;

        assign live = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign left_entry = ctrl.ent;
        end
        else
        begin : g_body
            assign prev_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .live        (live),
            .prev_gt     (prev_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        pri_next    = '0;
        tag_next    = '0;
        if (req.mode == MODE_SERVE)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                pri_next   = cell_entry[0].pri;
                tag_next   = cell_entry[0].tag;
                count_next = count_reg - 1'b1;
            end
        end
        else
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until a new item replaces it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pri_reg    <= pri_next;
            tag_reg    <= tag_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.served_priority = pri_reg;
    assign rsp.served_tag      = tag_reg;
    assign rsp.occupancy       = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not add an entry");

    a_serve_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.srv |=> (rsp.served_priority == $past(cell_entry[0].pri)
                      && rsp.status == ST_OK))
        else $error("serve did not return the head entry");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == MODE_SERVE && empty)
            |=> (rsp.status == ST_EMPTY && count_reg == '0))
        else $error("serve on empty queue mishandled");

endmodule

`default_nettype wire
